// ----- rtl/tir_pkg.sv -----
// tir_pkg: shared types and constants for the table interpolating reader
// used by tir_front, tir_back and table_interpolating_reader
package tir_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] REG_TABLE_SIZE    = 2'd0;
    localparam logic [1:0] REG_INTERP_MODE   = 2'd1;
    localparam logic [1:0] REG_EDGE_MODE     = 2'd2;
    localparam logic [1:0] REG_DEFAULT_VALUE = 2'd3;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SIZE_BITS      = 11;
    localparam int DEFAULT_BITS   = 16;

    typedef struct packed {
        logic [SIZE_BITS-1:0]    table_size;
        logic                    interp_mode;
        logic                    edge_mode;
        logic [DEFAULT_BITS-1:0] default_value;
    } cfg_t;

endpackage

// ----- rtl/tir_front.sv -----
// tir_front: accepts items, classifies them and resolves neighbor addresses
// depends on tir_pkg
module tir_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    parameter int ADDR_BITS   = 10,
    parameter int WADDR_BITS  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tir_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [WADDR_BITS-1:0]         write_address,
    input  logic signed [SAMPLE_BITS-1:0] write_value,
    input  logic signed [31:0]            read_index,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic                          q_is_read,
    output logic                          q_is_write,
    output logic                          q_use_default,
    output logic [4*ADDR_BITS-1:0]        q_addrs,
    output logic [FRAC_BITS-1:0]          q_frac,
    output logic [WADDR_BITS-1:0]         q_waddr,
    output logic signed [SAMPLE_BITS-1:0] q_wdata
);

    localparam int SB = ADDR_BITS + 2;
    localparam int IPB = 33 - FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(IPB + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;
    localparam logic [1:0] ST_ADDR  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic is_read_reg, is_write_reg, use_def_reg;
    logic [WADDR_BITS-1:0] waddr_reg;
    logic signed [SAMPLE_BITS-1:0] wdata_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [SB-1:0] size_reg;
    logic [IPB-1:0] rem_src_reg;
    logic [SB-1:0] rem_reg;
    logic neg_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [4*ADDR_BITS-1:0] addrs_reg;

    logic [SB-1:0] size_eff;
    logic [SB-1:0] last;
    logic signed [32:0] ip_full;
    logic [SB-1:0] rem_shift, rem_sub;
    logic [SB-1:0] ipw, i0w, i2w, i3w;
    logic [SB-1:0] i0c, i2c, i3c, ipc;
    logic [FRAC_BITS-1:0] fc;

    always_comb
    begin
        if (32'(cfg.table_size) > 32'(TABLE_DEPTH))
            size_eff = SB'(TABLE_DEPTH);
        else
            size_eff = SB'(cfg.table_size);
    end
    assign last = size_eff - SB'(1);
    assign ip_full = 33'(read_index) >>> FRAC_BITS;

    // clamp mode resolved in one step
    always_comb
    begin
        fc  = read_index[FRAC_BITS-1:0];
        ipc = SB'(ip_full);
        if (read_index[31])
        begin
            ipc = '0;
            fc  = '0;
        end
        else if (ip_full >= 33'(last))
        begin
            ipc = last;
            fc  = '0;
        end
        i0c = (ipc != '0) ? ipc - SB'(1) : '0;
        i2c = (ipc < last) ? ipc + SB'(1) : last;
        i3c = (ipc + SB'(1) < last) ? ipc + SB'(2) : last;
    end

    // restoring remainder step for wrap mode
    assign rem_shift = {rem_reg[SB-2:0], rem_src_reg[IPB-1]};
    assign rem_sub   = (rem_shift >= size_reg) ? rem_shift - size_reg : rem_shift;

    always_comb
    begin
        ipw = (neg_reg && rem_reg != '0) ? size_reg - rem_reg : rem_reg;
        i0w = (ipw == '0) ? size_reg - SB'(1) : ipw - SB'(1);
        i2w = (ipw + SB'(1) >= size_reg) ? ipw + SB'(1) - size_reg : ipw + SB'(1);
        i3w = (ipw + SB'(2) >= size_reg) ? ipw + SB'(2) - size_reg : ipw + SB'(2);
        if (i3w >= size_reg)
            i3w = i3w - size_reg;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (command == tir_pkg::CMD_READ && size_eff != '0 && cfg.edge_mode)
                        state_next = ST_DIV;
                    else
                        state_next = ST_OUT;
                end
            ST_DIV:
                if (cnt_reg == '0)
                    state_next = ST_ADDR;
            ST_ADDR:
                state_next = ST_OUT;
            ST_OUT:
                if (q_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            is_read_reg  <= (command == tir_pkg::CMD_READ);
            is_write_reg <= (command == tir_pkg::CMD_WRITE)
                            && (32'(write_address) < 32'(TABLE_DEPTH));
            use_def_reg  <= (size_eff == '0);
            waddr_reg    <= write_address;
            wdata_reg    <= write_value;
            size_reg     <= size_eff;
            rem_reg      <= '0;
            cnt_reg      <= DIV_CNT_BITS'(IPB - 1);
            if (cfg.edge_mode)
            begin
                frac_reg    <= read_index[FRAC_BITS-1:0];
                neg_reg     <= ip_full[32];
                rem_src_reg <= ip_full[32] ? IPB'(-ip_full) : IPB'(ip_full);
            end
            else
            begin
                frac_reg  <= fc;
                addrs_reg <= {ADDR_BITS'(i3c), ADDR_BITS'(i2c),
                              ADDR_BITS'(ipc), ADDR_BITS'(i0c)};
            end
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg     <= rem_sub;
            rem_src_reg <= {rem_src_reg[IPB-2:0], 1'b0};
            cnt_reg     <= cnt_reg - DIV_CNT_BITS'(1);
        end
        else if (state_reg == ST_ADDR)
        begin
            // final wrap addresses need the finished remainder
            addrs_reg <= {ADDR_BITS'(i3w), ADDR_BITS'(i2w),
                          ADDR_BITS'(ipw), ADDR_BITS'(i0w)};
        end
    end

    assign q_valid       = (state_reg == ST_OUT);
    assign q_is_read     = is_read_reg;
    assign q_is_write    = is_write_reg;
    assign q_use_default = use_def_reg;
    assign q_addrs       = addrs_reg;
    assign q_frac        = frac_reg;
    assign q_waddr       = waddr_reg;
    assign q_wdata       = wdata_reg;

endmodule

// ----- rtl/tir_back.sv -----
// tir_back: table memory, fetches and linear or cubic interpolation
// depends on tir_pkg
module tir_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    parameter int ADDR_BITS   = 10,
    parameter int WADDR_BITS  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tir_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic                          q_is_read,
    input  logic                          q_is_write,
    input  logic                          q_use_default,
    input  logic [4*ADDR_BITS-1:0]        q_addrs,
    input  logic [FRAC_BITS-1:0]          q_frac,
    input  logic [WADDR_BITS-1:0]         q_waddr,
    input  logic signed [SAMPLE_BITS-1:0] q_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int SW = SAMPLE_BITS + 6;
    localparam int PW = SW + FRAC_BITS + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_LIN   = 4'd2;
    localparam logic [3:0] ST_COEF  = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [2:0] fetch_reg;
    logic rd_pending_reg;
    logic [1:0] rd_slot_reg;
    logic signed [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg [4];
    logic [4*ADDR_BITS-1:0] addrs_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic signed [SW-1:0] a_reg, b_reg, c_reg, t_reg;
    logic out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic mode_reg;

    logic [ADDR_BITS-1:0] raddr;
    logic signed [SW-1:0] x0, x1, x2, x3;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] mul_in;
    logic signed [PW-1:0] lin_sum;
    logic signed [SW+1:0] h_sum;
    logic signed [SAMPLE_BITS-1:0] sat_v;
    logic signed [PW-1:0] sat_in;
    logic signed [PW-1:0] shifted;

    localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PW-1:0] MINV = -PW'(64'sd1 <<< (SAMPLE_BITS - 1));

    assign x0 = SW'(x_reg[0]);
    assign x1 = SW'(x_reg[1]);
    assign x2 = SW'(x_reg[2]);
    assign x3 = SW'(x_reg[3]);

    assign raddr = addrs_reg[fetch_reg[1:0]*ADDR_BITS +: ADDR_BITS];

    always_comb
    begin
        unique case (state_reg)
            ST_M1:   mul_in = a_reg;
            default: mul_in = t_reg;
        endcase
    end
    assign prod    = PW'(mul_in) * $signed({1'b0, frac_reg});
    assign shifted = prod >>> FRAC_BITS;
    assign lin_sum = (PW'(x1) <<< FRAC_BITS) + PW'(x2 - x1) * $signed({1'b0, frac_reg})
                     + PW'(64'sd1 <<< (FRAC_BITS - 1));
    assign h_sum   = ((SW+2)'(x1) <<< 1) + (SW+2)'(t_reg) + (SW+2)'(1);

    always_comb
    begin
        unique case (state_reg)
            ST_LIN:  sat_in = lin_sum >>> FRAC_BITS;
            default: sat_in = PW'(h_sum >>> 1);
        endcase
        if (sat_in > MAXV)
            sat_v = SAMPLE_BITS'(MAXV);
        else if (sat_in < MINV)
            sat_v = SAMPLE_BITS'(MINV);
        else
            sat_v = SAMPLE_BITS'(sat_in);
    end

    assign q_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && q_ready && q_is_read && !q_use_default)
                    state_next = ST_FETCH;
            ST_FETCH:
                if (!rd_pending_reg && fetch_reg == 3'd4)
                    state_next = mode_reg ? ST_COEF : ST_LIN;
            ST_LIN:  state_next = ST_IDLE;
            ST_COEF: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            rd_pending_reg <= 1'b0;
            fetch_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && q_valid && q_ready && q_is_read && q_use_default)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_LIN || state_reg == ST_FIN)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_IDLE)
            begin
                fetch_reg      <= '0;
                rd_pending_reg <= 1'b0;
            end
            else if (state_reg == ST_FETCH)
            begin
                rd_pending_reg <= (fetch_reg != 3'd4);
                if (fetch_reg != 3'd4)
                    fetch_reg <= fetch_reg + 3'd1;
            end
        end
    end

    // single port table: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready && q_is_write)
            mem[ADDR_BITS'(q_waddr)] <= q_wdata;
        else if (state_reg == ST_FETCH && fetch_reg != 3'd4)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready)
        begin
            addrs_reg <= q_addrs;
            frac_reg  <= q_frac;
            mode_reg  <= cfg.interp_mode;
            out_reg   <= SAMPLE_BITS'($signed(cfg.default_value));
        end
        if (state_reg == ST_FETCH)
        begin
            rd_slot_reg <= fetch_reg[1:0];
            if (rd_pending_reg)
                x_reg[rd_slot_reg] <= rdata_reg;
        end
        if (state_reg == ST_LIN || state_reg == ST_FIN)
            out_reg <= sat_v;
        if (state_reg == ST_COEF)
        begin
            a_reg <= SW'(3) * (x1 - x2) - x0 + x3;
            b_reg <= SW'(4) * x2 + SW'(2) * x0 - SW'(5) * x1 - x3;
            c_reg <= x2 - x0;
        end
        if (state_reg == ST_M1)
            t_reg <= SW'(shifted) + b_reg;
        if (state_reg == ST_M2)
            t_reg <= SW'(shifted) + c_reg;
        if (state_reg == ST_M3)
            t_reg <= SW'(shifted);
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule

// ----- rtl/table_interpolating_reader.sv -----
// table_interpolating_reader: sample table with linear or cubic hermite reads
// depends on tir_pkg, tir_front and tir_back
// a write goes to the table when the back accepts it; a read makes four fetches
// from the single port table, then interpolates (linear) or runs the coefficient
// steps (hermite); wrap mode first runs the bit serial modulo in the front; a
// default read returns the default value; the back takes a new item only
// after its result has been taken, one item can wait in the front meanwhile
// reset clears control and configuration; table contents are undefined
module table_interpolating_reader #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [9:0]                    write_address,
    input  logic signed [SAMPLE_BITS-1:0] write_value,
    input  logic signed [31:0]            read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

    tir_pkg::cfg_t cfg_reg;
    logic q_valid, q_ready, q_is_read, q_is_write, q_use_default;
    logic [4*ADDR_BITS-1:0] q_addrs;
    logic [FRAC_BITS-1:0] q_frac;
    logic [9:0] q_waddr;
    logic signed [SAMPLE_BITS-1:0] q_wdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                8'(tir_pkg::REG_TABLE_SIZE):    cfg_reg.table_size <= cfg_data[10:0];
                8'(tir_pkg::REG_INTERP_MODE):   cfg_reg.interp_mode <= cfg_data[0];
                8'(tir_pkg::REG_EDGE_MODE):     cfg_reg.edge_mode <= cfg_data[0];
                8'(tir_pkg::REG_DEFAULT_VALUE): cfg_reg.default_value <= cfg_data;
                default: ;
            endcase
        end
    end

    tir_front #(
        .TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS),
        .ADDR_BITS(ADDR_BITS), .WADDR_BITS(10)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .write_address(write_address), .write_value(write_value),
        .read_index(read_index),
        .q_valid(q_valid), .q_ready(q_ready), .q_is_read(q_is_read),
        .q_is_write(q_is_write), .q_use_default(q_use_default),
        .q_addrs(q_addrs), .q_frac(q_frac), .q_waddr(q_waddr), .q_wdata(q_wdata)
    );

    tir_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS),
        .ADDR_BITS(ADDR_BITS), .WADDR_BITS(10)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_is_read(q_is_read),
        .q_is_write(q_is_write), .q_use_default(q_use_default),
        .q_addrs(q_addrs), .q_frac(q_frac), .q_waddr(q_waddr), .q_wdata(q_wdata),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
    );

endmodule
